// File: hdl/btf_pkg.sv
// Shared types and constants of the bilinear texture filter.
package btf_pkg;

	// Input item operation codes.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_REPEAT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam int ADDR_W  = 16;
	localparam int SIDE_W  = 9;
	localparam int CHAN_W  = 8;
	localparam int OUT_W   = 16;
	localparam int COORD_W = 32;

	// Configuration write item.
	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_item_t;

	// Input item.
	typedef struct packed {
		logic                operation;
		logic [ADDR_W-1:0]   texel_index;
		logic [CHAN_W-1:0]   texel_red;
		logic [CHAN_W-1:0]   texel_green;
		logic [CHAN_W-1:0]   texel_blue;
		logic [CHAN_W-1:0]   texel_alpha;
		logic signed [COORD_W-1:0] coord_s;
		logic signed [COORD_W-1:0] coord_t;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [OUT_W-1:0] out_red;
		logic [OUT_W-1:0] out_green;
		logic [OUT_W-1:0] out_blue;
		logic [OUT_W-1:0] out_alpha;
	} out_item_t;

	// Registered configuration seen by the datapath.
	typedef struct packed {
		logic              repeat_mode;
		logic [SIDE_W-1:0] width;
		logic [SIDE_W-1:0] height;
	} cfg_t;

endpackage

// File: hdl/btf_if.sv
// Valid/ready channel interfaces of the bilinear texture filter.
interface btf_in_if import btf_pkg::*; ();
	logic      valid;
	logic      ready;
	in_item_t  item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface btf_out_if import btf_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface btf_cfg_if import btf_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// File: hdl/bilinear_texture_filter_top.sv
// Top level of the bilinear texture filter.
// Usage: configuration writes arrive on cfg (index 0 repeat mode, 1 width,
// 2 height) while the block is idle. Input items arrive on in_ch: a write
// item stores one RGBA texel, a sample item returns one filtered item on
// out_ch in unsigned Q8.8 per channel.
// Throughput: one item per cycle while out_ch is not stalled. The texel memory
// is held as four full copies, each written by every write item and read at
// one neighbor address per cycle, so the four neighbors of a sample are read
// in the same cycle. A sample passes two coordinate stages, one address stage,
// one memory read stage and three blend stages before its result is valid.
// Reset clears the valid bits of all stages and the configuration to repeat
// off, width 1, height 1; the texel memory is not cleared.
// When out_ch stalls the whole pipeline holds; in_ch.ready follows
// out_ch.ready while the last stage is full, so nothing is lost or repeated.
module bilinear_texture_filter_top import btf_pkg::*; #(
	parameter int MAX_SIDE        = 256,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	btf_cfg_if.sink   cfg,
	btf_in_if.sink    in_ch,
	btf_out_if.source out_ch
);
	localparam int IW = $clog2(MAX_SIDE);
	localparam int F  = COORD_FRAC_BITS;
	localparam int NS = 7;
	localparam int BD = 2 ** (ADDR_W - 2);

	cfg_t cfg_q;
	logic [NS-1:0] vld_q;
	logic en;
	logic [NS-1:0] smp_q;

	// Whole pipeline advances unless the last stage holds a stalled item.
	assign en           = !vld_q[NS-1] || out_ch.ready;
	assign in_ch.ready  = en;
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = vld_q[NS-1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{repeat_mode: 1'b0, width: SIDE_W'(1), height: SIDE_W'(1)};
		end else if (cfg.valid) begin
			case (cfg.item.index)
				REG_REPEAT: cfg_q.repeat_mode <= cfg.item.data[0];
				REG_WIDTH:  cfg_q.width       <= cfg.item.data[SIDE_W-1:0];
				REG_HEIGHT: cfg_q.height      <= cfg.item.data[SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits; only samples produce results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q <= '0;
		end else if (en) begin
			smp_q <= {smp_q[NS-2:0], in_ch.valid && in_ch.item.operation == OP_SAMPLE};
		end
	end
	assign vld_q = smp_q;

	// Write path delayed to meet the memory stage, keeping item order.
	logic        wr_s1, wr_s2, wr_s3;
	logic [ADDR_W-1:0] wa_s1, wa_s2, wa_s3;
	logic [31:0] wd_s1, wd_s2, wd_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			wr_s2 <= 1'b0;
			wr_s3 <= 1'b0;
		end else if (en) begin
			wr_s1 <= in_ch.valid && in_ch.item.operation == OP_WRITE;
			wr_s2 <= wr_s1;
			wr_s3 <= wr_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			wa_s1 <= in_ch.item.texel_index;
			wd_s1 <= {in_ch.item.texel_alpha, in_ch.item.texel_blue,
				in_ch.item.texel_green, in_ch.item.texel_red};
			wa_s2 <= wa_s1;
			wd_s2 <= wd_s1;
			wa_s3 <= wa_s2;
			wd_s3 <= wd_s2;
		end
	end

	// Coordinate stages one and two.
	logic [IW-1:0] x0_s2, x1_s2, y0_s2, y1_s2;
	logic [F:0]    u_s2, v_s2;
	btf_locate #(.MAX_SIDE(MAX_SIDE), .FRAC(F)) u_loc_x (
		.clk(clk), .en(en), .repeat_mode(cfg_q.repeat_mode), .side(cfg_q.width),
		.coord(in_ch.item.coord_s), .lo(x0_s2), .hi(x1_s2), .frac(u_s2)
	);
	btf_locate #(.MAX_SIDE(MAX_SIDE), .FRAC(F)) u_loc_y (
		.clk(clk), .en(en), .repeat_mode(cfg_q.repeat_mode), .side(cfg_q.height),
		.coord(in_ch.item.coord_t), .lo(y0_s2), .hi(y1_s2), .frac(v_s2)
	);

	// Stage three: addresses of the four neighbors (each row times width is one multiply).
	logic [ADDR_W-1:0] a_s3 [4];
	logic [F:0] u_s3, v_s3;
	logic [ADDR_W-1:0] row0, row1;
	logic [SIDE_W-1:0] w_eff;
	always_comb begin
		if (cfg_q.width == '0) begin
			w_eff = SIDE_W'(1);
		end else if (32'(cfg_q.width) > MAX_SIDE) begin
			w_eff = SIDE_W'(MAX_SIDE);
		end else begin
			w_eff = cfg_q.width;
		end
		row0 = ADDR_W'(32'(y0_s2) * 32'(w_eff));
		row1 = ADDR_W'(32'(y1_s2) * 32'(w_eff));
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3[0] <= row0 + ADDR_W'(x0_s2);
			a_s3[1] <= row0 + ADDR_W'(x1_s2);
			a_s3[2] <= row1 + ADDR_W'(x0_s2);
			a_s3[3] <= row1 + ADDR_W'(x1_s2);
			u_s3    <= u_s2;
			v_s3    <= v_s2;
		end
	end

	// Four banks, one per neighbor address; the four addresses may coincide, so
	// each bank is a full copy written in parallel and read once.
	logic [31:0] bank0 [BD*4];
	logic [31:0] bank1 [BD*4];
	logic [31:0] bank2 [BD*4];
	logic [31:0] bank3 [BD*4];
	logic [31:0] t_s4 [4];
	logic [F:0] u_s4, v_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_s3) begin
				bank0[wa_s3] <= wd_s3;
			end
			t_s4[0] <= bank0[a_s3[0]];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_s3) begin
				bank1[wa_s3] <= wd_s3;
			end
			t_s4[1] <= bank1[a_s3[1]];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_s3) begin
				bank2[wa_s3] <= wd_s3;
			end
			t_s4[2] <= bank2[a_s3[2]];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_s3) begin
				bank3[wa_s3] <= wd_s3;
			end
			t_s4[3] <= bank3[a_s3[3]];
			u_s4 <= u_s3;
			v_s4 <= v_s3;
		end
	end

	// Blend stages five to seven, one lane per channel.
	logic [OUT_W-1:0] res [4];
	for (genvar ch = 0; ch < 4; ch++) begin : g_chan
		btf_blend #(.FRAC(F)) u_blend (
			.clk(clk), .en(en),
			.c00(t_s4[0][ch*8 +: 8]), .c01(t_s4[1][ch*8 +: 8]),
			.c10(t_s4[2][ch*8 +: 8]), .c11(t_s4[3][ch*8 +: 8]),
			.u({1'b0, u_s4}), .v({1'b0, v_s4}), .result(res[ch])
		);
	end

	assign out_ch.item = '{out_red: res[0], out_green: res[1],
		out_blue: res[2], out_alpha: res[3]};
endmodule

// File: hdl/btf_locate.sv
// One axis: wrap or clamp a coordinate, scale it, split index and fraction (two stages).
module btf_locate import btf_pkg::*; #(
	parameter int MAX_SIDE = 256,
	parameter int FRAC     = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic                      repeat_mode,
	input  logic [SIDE_W-1:0]         side,
	input  logic signed [COORD_W-1:0] coord,
	output logic [$clog2(MAX_SIDE)-1:0] lo,
	output logic [$clog2(MAX_SIDE)-1:0] hi,
	output logic [FRAC:0]             frac
);
	localparam int IW = $clog2(MAX_SIDE);
	localparam int CW = FRAC + 1;
	localparam int MW = IW + 1;
	localparam int PW = CW + MW;

	logic [CW-1:0] c_norm;
	logic [IW:0]   side_eff;
	logic [CW-1:0] c_s1;
	logic [MW-1:0] mul_s1;
	logic [IW:0]   last_s1;
	logic [PW-1:0] p;
	logic [PW-FRAC-2:0] idx_full;
	logic [IW-1:0] idx;

	// Wrap to the fraction or clamp to zero..one.
	always_comb begin
		if (repeat_mode) begin
			c_norm = {1'b0, coord[FRAC-1:0]};
		end else if (coord[COORD_W-1]) begin
			c_norm = '0;
		end else if (coord > (COORD_W'(1) << FRAC)) begin
			c_norm = CW'(1) << FRAC;
		end else begin
			c_norm = coord[CW-1:0];
		end
		if (side == '0) begin
			side_eff = (IW+1)'(1);
		end else if (32'(side) > MAX_SIDE) begin
			side_eff = (IW+1)'(MAX_SIDE);
		end else begin
			side_eff = (IW+1)'(side);
		end
	end

	// Stage one: normalized coordinate and scale factor 2*side-1.
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1    <= c_norm;
			mul_s1  <= MW'({side_eff, 1'b0} - 1'b1);
			last_s1 <= side_eff - 1'b1;
		end
	end

	// Stage two: product, index clamp and fraction.
	assign p        = PW'(c_s1) * PW'(mul_s1);
	assign idx_full = p[PW-1:FRAC+1];
	assign idx      = ((IW+1)'(idx_full) > last_s1) ? last_s1[IW-1:0] : idx_full[IW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			lo   <= idx;
			hi   <= ((IW+1)'(idx) + 1'b1 > last_s1) ? last_s1[IW-1:0] : idx + 1'b1;
			frac <= p[FRAC:0];
		end
	end
endmodule

// File: hdl/btf_blend.sv
// Bilinear blend of one channel over three register stages.
module btf_blend import btf_pkg::*; #(
	parameter int FRAC = 16
) (
	input  logic              clk,
	input  logic              en,
	input  logic [CHAN_W-1:0] c00,
	input  logic [CHAN_W-1:0] c01,
	input  logic [CHAN_W-1:0] c10,
	input  logic [CHAN_W-1:0] c11,
	input  logic [FRAC+1:0]   u,
	input  logic [FRAC+1:0]   v,
	output logic [OUT_W-1:0]  result
);
	localparam int WF = FRAC + 2;
	localparam int RW = CHAN_W + WF;
	localparam int AW = RW + WF + 1;
	localparam int SH = 2 * (FRAC + 1) - 8;

	logic [WF-1:0] su;
	logic [RW-1:0] r0_s1, r1_s1;
	logic [WF-1:0] v_s1;
	logic [AW-1:0] a0_s2, a1_s2;
	logic [AW-1:0] acc;

	assign su = (WF'(1) << (FRAC + 1)) - u;

	// Stage one: horizontal blend of both rows.
	always_ff @(posedge clk) begin
		if (en) begin
			r0_s1 <= RW'(c00) * RW'(su) + RW'(c01) * RW'(u);
			r1_s1 <= RW'(c10) * RW'(su) + RW'(c11) * RW'(u);
			v_s1  <= v;
		end
	end

	// Stage two: vertical weights.
	always_ff @(posedge clk) begin
		if (en) begin
			a0_s2 <= AW'(r0_s1) * AW'((WF'(1) << (FRAC + 1)) - v_s1);
			a1_s2 <= AW'(r1_s1) * AW'(v_s1);
		end
	end

	// Stage three: sum and round to Q8.8, ties upward.
	assign acc = a0_s2 + a1_s2 + (AW'(1) << (SH - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			result <= acc[SH +: OUT_W];
		end
	end
endmodule

// File: hdl/btf_checker.sv
// Port-level checker of the bilinear texture filter and its bind.
module btf_checker import btf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_op,
	input logic out_valid,
	input logic out_ready,
	input out_item_t out_item
);
	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// The input is never refused while the output is free.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

	// Red and alpha results stay within Q8.8 texel range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.out_red <= 16'hFF00 && out_item.out_alpha <= 16'hFF00)
		else $error("result out of range");

	// A write item yields no result when it would reach the output on a free-running pipe.
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == OP_WRITE ##1 out_ready ##1 out_ready
		##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> !out_valid)
		else $error("result from a write item");
endmodule

bind bilinear_texture_filter_top btf_checker u_btf_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.item.operation),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.item)
);

// File: tb/bilinear_texture_filter_top_tb.sv
// Self-checking testbench of the bilinear texture filter: predicted samples against the block.
module bilinear_texture_filter_top_tb import btf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC     = 16;
	localparam int POSF     = FRAC + 1;
	localparam int LIMIT    = 400000;
	localparam int LATENCY  = 7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	btf_cfg_if cfg ();
	btf_in_if  in_ch ();
	btf_out_if out_ch ();

	bilinear_texture_filter_top uut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
	);

	always #5 clk = ~clk;

	// Model state of the filter.
	logic [31:0] texels [int];
	logic        mdl_repeat;
	int          mdl_width;
	int          mdl_height;
	out_item_t   pending_samples [$];

	int  errors = 0;
	int  cycles = 0;
	bit  idle_enable = 1'b1;
	bit  hold_out = 1'b0;
	int  hold_cycles = 0;

	initial begin
		cfg.valid = 1'b0;
		cfg.item = '0;
		in_ch.valid = 1'b0;
		in_ch.item = '0;
		out_ch.ready = 1'b0;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("bilinear_texture_filter_top_tb: FAIL");
			$finish;
		end
	end

	function automatic longint norm_coord(logic [31:0] raw);
		longint v;
		v = longint'($signed(raw));
		if (mdl_repeat) return longint'(raw[FRAC-1:0]);
		if (v < 0) return 0;
		if (v > (longint'(1) << FRAC)) return longint'(1) << FRAC;
		return v;
	endfunction

	function automatic void locate_axis(input longint c, input int side, output longint lo,
		output longint hi, output longint frac);
		longint p;
		p = c * (2 * side - 1);
		lo = p >>> POSF;
		if (lo > side - 1) lo = side - 1;
		hi = (lo + 1 > side - 1) ? side - 1 : lo + 1;
		frac = p & ((longint'(1) << POSF) - 1);
	endfunction

	function automatic logic [31:0] texel_at(longint row, longint col, int w);
		logic [15:0] a;
		a = 16'((row * w + col) & 16'hFFFF);
		return texels.exists(a) ? texels[a] : 32'h0;
	endfunction

	function automatic out_item_t filter_sample(in_item_t it);
		longint x0, x1, y0, y1, u, v, su, sv, acc, one;
		logic [31:0] t00, t01, t10, t11;
		logic [15:0] ch [4];
		out_item_t r;
		locate_axis(norm_coord(it.coord_s), mdl_width, x0, x1, u);
		locate_axis(norm_coord(it.coord_t), mdl_height, y0, y1, v);
		one = longint'(1) << POSF;
		su = one - u;
		sv = one - v;
		t00 = texel_at(y0, x0, mdl_width);
		t01 = texel_at(y0, x1, mdl_width);
		t10 = texel_at(y1, x0, mdl_width);
		t11 = texel_at(y1, x1, mdl_width);
		for (int k = 0; k < 4; k++) begin
			acc = (longint'(t00[k*8 +: 8]) * su + longint'(t01[k*8 +: 8]) * u) * sv
				+ (longint'(t10[k*8 +: 8]) * su + longint'(t11[k*8 +: 8]) * u) * v;
			ch[k] = 16'((acc + (longint'(1) << (2 * POSF - 9))) >>> (2 * POSF - 8));
		end
		r.out_red = ch[0];
		r.out_green = ch[1];
		r.out_blue = ch[2];
		r.out_alpha = ch[3];
		return r;
	endfunction

	// Random idle burst on the sending side; valid drops for its length.
	task automatic idle_gap();
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Send one input item and update the model on acceptance.
	task automatic send_item(in_item_t it);
		idle_gap();
		in_ch.valid <= 1'b1;
		in_ch.item <= it;
		do @(posedge clk); while (!in_ch.ready);
		if (it.operation == OP_WRITE)
			texels[it.texel_index] = {it.texel_alpha, it.texel_blue, it.texel_green,
				it.texel_red};
		else
			pending_samples.push_back(filter_sample(it));
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		cfg.valid <= 1'b1;
		cfg.item <= '{index: idx, data: 32'(val)};
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_REPEAT: mdl_repeat = val[0];
			REG_WIDTH:  mdl_width = (val[8:0] < 1) ? 1 : (val[8:0] > 256 ? 256 : val[8:0]);
			REG_HEIGHT: mdl_height = (val[8:0] < 1) ? 1 : (val[8:0] > 256 ? 256 : val[8:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Stop sending and wait until every sample has come back.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic in_item_t texel_write(int addr);
		in_item_t it;
		it = '0;
		it.operation = OP_WRITE;
		it.texel_index = 16'(addr);
		it.texel_red = 8'($urandom);
		it.texel_green = 8'($urandom);
		it.texel_blue = 8'($urandom);
		it.texel_alpha = 8'($urandom);
		it.coord_s = $urandom;
		it.coord_t = $urandom;
		return it;
	endfunction

	function automatic in_item_t sample_item(logic [31:0] s, logic [31:0] t);
		in_item_t it;
		it = texel_write(0);
		it.operation = OP_SAMPLE;
		it.texel_index = 16'($urandom);
		it.coord_s = s;
		it.coord_t = t;
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($urandom_range(0, 32'h10000));
			2: return 32'h10000;
			3: return 32'h80000000 | 32'($urandom_range(0, 3)) << 16;
			4: return 32'($signed(-$urandom_range(1, 4))) << 16;
			default: return 32'($urandom_range(0, 32'h30000)) - 32'h18000;
		endcase
	endfunction

	// Configure a size and fill the whole texture rectangle.
	task automatic setup_texture(bit rep, int w, int h);
		write_reg(REG_REPEAT, rep);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		for (int a = 0; a < mdl_width * mdl_height; a++) send_item(texel_write(a));
	endtask

	// Extreme coordinates, both modes, texel field extremes.
	task automatic test_directed();
		in_item_t it;
		setup_texture(1'b0, 2, 2);
		it = texel_write(0);
		it.texel_red = 8'hFF; it.texel_green = 8'h00;
		it.texel_blue = 8'hFF; it.texel_alpha = 8'h00;
		send_item(it);
		it = texel_write(3);
		it.texel_red = 8'h00; it.texel_green = 8'hFF;
		it.texel_blue = 8'h00; it.texel_alpha = 8'hFF;
		send_item(it);
		send_item(sample_item(32'h0, 32'h0));
		send_item(sample_item(32'h10000, 32'h10000));
		send_item(sample_item(32'h7FFFFFFF, 32'h80000000));
		send_item(sample_item(32'h80000000, 32'h7FFFFFFF));
		send_item(sample_item(32'h8000, 32'h8000));
		send_item(sample_item(32'hFFFFFFFF, 32'h0000FFFF));
		drain();
		write_reg(REG_REPEAT, 1);
		send_item(sample_item(32'hFFFE0000, 32'hFFFF0000));
		send_item(sample_item(32'h7FFFFFFF, 32'h80000000));
		send_item(sample_item(32'hFFFF8000, 32'h00018000));
		drain();
		// Side of zero and above the maximum.
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 9'h1FF);
		for (int a = 0; a < 256; a++) send_item(texel_write(a));
		send_item(sample_item(32'h10000, 32'h10000));
		send_item(sample_item(32'h8000, 32'hC000));
		drain();
	endtask

	// Random samples over one given texture size with writes mixed in.
	task automatic test_random(int n, bit rep, int w, int h);
		setup_texture(rep, w, h);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_item(texel_write($urandom_range(0, mdl_width * mdl_height - 1)));
			else
				send_item(sample_item(rand_coord(), rand_coord()));
		end
		drain();
	endtask

	// Long output stall while input keeps coming.
	task automatic test_backpressure();
		hold_cycles = 60;
		hold_out = 1'b1;
		for (int i = 0; i < 40; i++) send_item(sample_item(rand_coord(), rand_coord()));
		drain();
	endtask

	// Output ready, with random stalls and a held-off stretch; always ready once idle_enable is cleared.
	always @(posedge clk) begin
		if (hold_out) begin
			out_ch.ready <= 1'b0;
			if (hold_cycles == 0) hold_out <= 1'b0;
			else hold_cycles <= hold_cycles - 1;
		end else if (!idle_enable) begin
			out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(0, 4) != 0);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_samples.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected sample result %h", out_ch.item);
			end else begin
				want = pending_samples.pop_front();
				if (want !== out_ch.item) begin
					errors++;
					if (errors <= 10)
						$display("sample mismatch: expected r%h g%h b%h a%h got r%h g%h b%h a%h",
							want.out_red, want.out_green, want.out_blue, want.out_alpha,
							out_ch.item.out_red, out_ch.item.out_green,
							out_ch.item.out_blue, out_ch.item.out_alpha);
				end
			end
		end
	end

	initial begin
		mdl_repeat = 1'b0;
		mdl_width = 1;
		mdl_height = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(100, 1'b0, 1, 1);
		test_random(150, 1'b1, 4, 3);
		test_random(150, 1'b0, 5, 8);
		test_backpressure();
		test_random(100, 1'b1, 32, 2);
		test_random(100, 1'b0, 2, 32);
		idle_enable = 1'b0;
		test_random(150, 1'b1, 7, 6);
		if (pending_samples.size() == 0 && errors == 0) begin
			$display("bilinear_texture_filter_top_tb: PASS");
		end else begin
			$display("bilinear_texture_filter_top_tb: FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/btf_pkg.sv
hdl/btf_if.sv
hdl/btf_locate.sv
hdl/btf_blend.sv
hdl/bilinear_texture_filter_top.sv
hdl/btf_checker.sv
tb/bilinear_texture_filter_top_tb.sv
